@@ rtl/wsht_pkg.sv @@
// Shared types, constants and sequencer states for the window stack hit test.
package wsht_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int COORD_BITS  = 12;

  // Port field widths are fixed by the item format.
  localparam int IN_COORD_W = 12;
  localparam int NUM_W      = 5;

  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    coord_t lx;
    coord_t by;
    coord_t rx;
    coord_t ty;
  } rect_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ORD,
    ST_RD_RECT,
    ST_TEST,
    ST_SH_RD,
    ST_SH_WR,
    ST_TOP,
    ST_DONE
  } state_t;

endpackage

@@ rtl/wsht_if.sv @@
// Valid/ready channel interfaces for input items and click results.
interface wsht_in_if import wsht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IN_COORD_W-1:0] left_x;
  logic [IN_COORD_W-1:0] bottom_y;
  logic [IN_COORD_W-1:0] right_x;
  logic [IN_COORD_W-1:0] top_y;
  logic [IN_COORD_W-1:0] point_x;
  logic [IN_COORD_W-1:0] point_y;

  modport source (output valid, op, left_x, bottom_y, right_x, top_y, point_x, point_y,
                  input ready);
  modport sink   (input valid, op, left_x, bottom_y, right_x, top_y, point_x, point_y,
                  output ready);
endinterface

interface wsht_out_if import wsht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [NUM_W-1:0] window_number;

  modport source (output valid, hit, window_number, input ready);
  modport sink   (input valid, hit, window_number, output ready);
endinterface

@@ rtl/window_stack_hit_test.sv @@
// Top level: z-ordered window stack with click hit test and raise to top.
// Load: accepted while idle, no result. Click: accepted while idle, then each
//   window is tested from the top (read order, read rectangle, test), each window
//   above the hit is shifted down one position (read, write), the hit window is
//   placed on top, and the result is handed off once the output is free.
// The rate is set by the single order-list port and the one compare unit.
// Reset (rst_n low, synchronous) empties the stack and drops any result.
module window_stack_hit_test import wsht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wsht_in_if.sink    in_ch,
  wsht_out_if.source out_ch
);

  // Storage: rectangles by load order, window index per stack position
  // (position 0 is the bottom). Both are plain RAMs with registered reads.
  rect_t rect_mem  [MAX_WINDOWS];
  idx_t  order_mem [MAX_WINDOWS];

  state_t state_r, state_nxt;

  cnt_t   count_r, count_nxt;   // loaded windows
  cnt_t   pos_r,   pos_nxt;     // scan position + 1
  cnt_t   k_r,     k_nxt;       // shift position
  idx_t   w_r,     w_nxt;       // window under test / hit window
  point_t pt_r,    pt_nxt;
  logic   res_hit_r, res_hit_nxt;
  logic [NUM_W-1:0] res_num_r, res_num_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r,   out_hit_nxt;
  logic [NUM_W-1:0] out_num_r,   out_num_nxt;

  // RAM ports
  idx_t  ord_q;
  rect_t rect_q;
  idx_t  ord_raddr, rect_raddr, ord_waddr, ord_wdata;
  logic  ord_we, rect_we;
  rect_t rect_wdata;

  logic in_xfer, out_free, pt_hit;
  cnt_t pos_m1;
  logic [IDX_W:0] w_plus1;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pos_m1   = pos_r - cnt_t'(1);
  assign w_plus1  = {1'b0, w_r} + {{IDX_W{1'b0}}, 1'b1};

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.window_number = out_num_r;

  assign rect_wdata.lx = coord_t'(in_ch.left_x);
  assign rect_wdata.by = coord_t'(in_ch.bottom_y);
  assign rect_wdata.rx = coord_t'(in_ch.right_x);
  assign rect_wdata.ty = coord_t'(in_ch.top_y);

  wsht_point_test u_test (
    .rect   (rect_q),
    .pt     (pt_r),
    .pt_hit (pt_hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_ch.op == OP_CLICK) begin
          state_nxt = (count_r == '0) ? ST_DONE : ST_RD_ORD;
        end
      end
      ST_RD_ORD:  state_nxt = ST_RD_RECT;
      ST_RD_RECT: state_nxt = ST_TEST;
      ST_TEST: begin
        if (pt_hit) begin
          state_nxt = (pos_r < count_r) ? ST_SH_RD : ST_TOP;
        end else if (pos_r == cnt_t'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD_ORD;
        end
      end
      ST_SH_RD: state_nxt = ST_SH_WR;
      ST_SH_WR: begin
        // more windows above the new k+1?
        if (({1'b0, k_r} + (CNT_W+1)'(2)) < {1'b0, count_r}) begin
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_TOP;
        end
      end
      ST_TOP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ch.ready   = 1'b0;
    ord_raddr     = pos_m1[IDX_W-1:0];
    rect_raddr    = ord_q;
    ord_we        = 1'b0;
    ord_waddr     = k_r[IDX_W-1:0];
    ord_wdata     = ord_q;
    rect_we       = 1'b0;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    pt_nxt        = pt_r;
    res_hit_nxt   = res_hit_r;
    res_num_nxt   = res_num_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_num_nxt   = out_num_r;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_xfer) begin
          if (in_ch.op == OP_LOAD) begin
            // full stack: load dropped
            if (count_r < cnt_t'(MAX_WINDOWS)) begin
              rect_we   = 1'b1;
              ord_we    = 1'b1;
              ord_waddr = count_r[IDX_W-1:0];
              ord_wdata = count_r[IDX_W-1:0];
              count_nxt = count_r + cnt_t'(1);
            end
          end else begin
            pt_nxt.px   = coord_t'(in_ch.point_x);
            pt_nxt.py   = coord_t'(in_ch.point_y);
            pos_nxt     = count_r;
            res_hit_nxt = 1'b0;
            res_num_nxt = '0;
          end
        end
      end
      ST_RD_ORD: begin
        ord_raddr = pos_m1[IDX_W-1:0];
      end
      ST_RD_RECT: begin
        rect_raddr = ord_q;
        w_nxt      = ord_q;
      end
      ST_TEST: begin
        if (pt_hit) begin
          res_hit_nxt = 1'b1;
          res_num_nxt = NUM_W'(w_plus1);
          k_nxt       = pos_m1;
        end else begin
          pos_nxt = pos_m1;
        end
      end
      ST_SH_RD: begin
        ord_raddr = idx_t'(k_r + cnt_t'(1));
      end
      ST_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = k_r[IDX_W-1:0];
        ord_wdata = ord_q;
        k_nxt     = k_r + cnt_t'(1);
      end
      ST_TOP: begin
        ord_we    = 1'b1;
        ord_waddr = idx_t'(count_r - cnt_t'(1));
        ord_wdata = w_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_num_nxt   = res_num_r;
        end
      end
      default: ;
    endcase
  end

  // RAMs
  always_ff @(posedge clk) begin
    if (rect_we) rect_mem[count_r[IDX_W-1:0]] <= rect_wdata;
    rect_q <= rect_mem[rect_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    ord_q <= order_mem[ord_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    w_r       <= w_nxt;
    pt_r      <= pt_nxt;
    res_hit_r <= res_hit_nxt;
    res_num_r <= res_num_nxt;
    out_hit_r <= out_hit_nxt;
    out_num_r <= out_num_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_WINDOWS))
    else $error("window count above stack depth");

  a_count_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && in_ch.op == OP_LOAD) |=> $stable(count_r))
    else $error("window count changed without a load transfer");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SH_RD |-> ({1'b0, k_r} + (CNT_W+1)'(1)) < {1'b0, count_r})
    else $error("order shift beyond top of stack");

  a_miss_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_num_r == '0)
    else $error("miss reported with a window number");

  a_hit_goes_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TEST && pt_hit |=> state_r == ST_SH_RD || state_r == ST_TOP)
    else $error("hit did not start the raise sequence");

endmodule

@@ rtl/wsht_point_test.sv @@
// Shared compare unit: inclusive point-in-rectangle test.
module wsht_point_test import wsht_pkg::*; (
  input  rect_t  rect,
  input  point_t pt,
  output logic   pt_hit
);

  assign pt_hit = (pt.px >= rect.lx) && (pt.px <= rect.rx) &&
                  (pt.py >= rect.by) && (pt.py <= rect.ty);

endmodule
